### rtl/stbs_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sorted table search.
package stbs_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 4;

    typedef enum logic [STAT_W-1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_NOT_READY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_NOT_READY,
        DP_SRCH_INIT,
        DP_SRCH_PROBE,
        DP_SORT_INIT,
        DP_SORT_KEY,
        DP_SORT_SHIFT,
        DP_SORT_PLACE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic last_load;
        logic ready;
        logic probe_eq;
        logic probe_more;
        logic shift_gt;
        logic shift_last;
        logic sort_last;
    } dp_sts_t;

endpackage

### rtl/stbs_ctrl.sv
// Controller state machine that sequences loads, the table sort and the binary search.
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    mode,
    input  dp_sts_t dp_sts,
    output dp_cmd_t dp_cmd,
    output logic    busy,
    output logic    done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT_INIT,
        ST_SORT_KEY,
        ST_SORT_SHIFT,
        ST_SORT_PLACE,
        ST_SEARCH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        dp_cmd.op  = DP_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (!mode)
                    begin
                        dp_cmd.op = DP_LOAD;
                        // The request that fills the last slot kicks off the sort.
                        if (!dp_sts.full && dp_sts.last_load)
                        begin
                            state_next = ST_SORT_INIT;
                        end
                    end
                    else if (dp_sts.ready)
                    begin
                        dp_cmd.op  = DP_SRCH_INIT;
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        dp_cmd.op = DP_NOT_READY;
                        done_next = 1'b1;
                    end
                end
            end
            ST_SORT_INIT:
            begin
                dp_cmd.op  = DP_SORT_INIT;
                state_next = ST_SORT_KEY;
            end
            ST_SORT_KEY:
            begin
                dp_cmd.op  = DP_SORT_KEY;
                state_next = ST_SORT_SHIFT;
            end
            ST_SORT_SHIFT:
            begin
                if (dp_sts.shift_gt)
                begin
                    dp_cmd.op = DP_SORT_SHIFT;
                    if (dp_sts.shift_last)
                    begin
                        state_next = ST_SORT_PLACE;
                    end
                end
                else
                begin
                    dp_cmd.op  = DP_SORT_PLACE;
                    state_next = dp_sts.sort_last ? ST_IDLE : ST_SORT_KEY;
                end
            end
            ST_SORT_PLACE:
            begin
                dp_cmd.op  = DP_SORT_PLACE;
                state_next = dp_sts.sort_last ? ST_IDLE : ST_SORT_KEY;
            end
            ST_SEARCH:
            begin
                dp_cmd.op = DP_SRCH_PROBE;
                if (dp_sts.probe_eq || !dp_sts.probe_more)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

### rtl/stbs_dp.sv
// Datapath with the table memory, sort and search registers, and the result registers.
module stbs_dp
    import stbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  dp_cmd,
    input  logic signed [DATA_W-1:0] item_value,
    output dp_sts_t                  dp_sts,
    output logic [STAT_W-1:0]        status,
    output logic [POS_W-1:0]         position
);

    logic signed [DATA_W-1:0] mem [ENTRIES];

    logic signed [DATA_W-1:0] rd_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] key_next;
    logic [CNT_W-1:0]         lo_reg;
    logic [CNT_W-1:0]         lo_next;
    logic [CNT_W-1:0]         hp_reg;
    logic [CNT_W-1:0]         hp_next;
    logic [IDX_W-1:0]         mid_reg;
    logic [IDX_W-1:0]         mid_next;
    logic [IDX_W-1:0]         i_reg;
    logic [IDX_W-1:0]         i_next;
    logic [IDX_W-1:0]         j_reg;
    logic [IDX_W-1:0]         j_next;
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic                     ready_reg;
    logic                     ready_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [POS_W-1:0]         position_reg;
    logic [POS_W-1:0]         position_next;

    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    logic                     key_gt;
    logic [CNT_W-1:0]         lo_probe;
    logic [CNT_W-1:0]         hp_probe;
    logic [CNT_W:0]           mid_sum;
    logic [IDX_W-1:0]         mid_probe;
    logic [IDX_W-1:0]         mid_first;

    // Bounds are kept as lo and hi+1, so the interval is empty when lo equals hp.
    assign key_gt    = key_reg > rd_reg;
    assign lo_probe  = key_gt ? (CNT_W'(mid_reg) + CNT_W'(1)) : lo_reg;
    assign hp_probe  = key_gt ? hp_reg : CNT_W'(mid_reg);
    assign mid_sum   = {1'b0, lo_probe} + {1'b0, hp_probe} - (CNT_W + 1)'(1);
    assign mid_probe = IDX_W'(mid_sum >> 1);
    assign mid_first = IDX_W'((ENTRIES - 1) / 2);

    assign dp_sts.full       = (fill_reg == CNT_W'(ENTRIES));
    assign dp_sts.last_load  = (fill_reg == CNT_W'(ENTRIES - 1));
    assign dp_sts.ready      = ready_reg;
    assign dp_sts.probe_eq   = (rd_reg == key_reg);
    assign dp_sts.probe_more = (lo_probe < hp_probe);
    assign dp_sts.shift_gt   = rd_reg > key_reg;
    assign dp_sts.shift_last = (j_reg == IDX_W'(1));
    assign dp_sts.sort_last  = (i_reg == IDX_W'(ENTRIES - 1));

    assign status   = status_reg;
    assign position = position_reg;

    always_comb
    begin
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = key_reg;
        key_next      = key_reg;
        lo_next       = lo_reg;
        hp_next       = hp_reg;
        mid_next      = mid_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        fill_next     = fill_reg;
        ready_next    = ready_reg;
        status_next   = status_reg;
        position_next = position_reg;
        unique case (dp_cmd.op)
            DP_IDLE:
            begin
            end
            DP_LOAD:
            begin
                wr_en   = 1'b1;
                wr_data = item_value;
                if (dp_sts.full)
                begin
                    // A load into a full table starts a fresh table at entry zero.
                    wr_addr    = '0;
                    fill_next  = CNT_W'(1);
                    ready_next = 1'b0;
                end
                else
                begin
                    wr_addr   = fill_reg[IDX_W-1:0];
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            DP_NOT_READY:
            begin
                status_next   = STATUS_NOT_READY;
                position_next = '0;
            end
            DP_SRCH_INIT:
            begin
                key_next = item_value;
                lo_next  = '0;
                hp_next  = CNT_W'(ENTRIES);
                mid_next = mid_first;
                rd_addr  = mid_first;
            end
            DP_SRCH_PROBE:
            begin
                if (dp_sts.probe_eq)
                begin
                    status_next   = STATUS_FOUND;
                    position_next = POS_W'(mid_reg);
                end
                else
                begin
                    status_next   = STATUS_NOT_FOUND;
                    position_next = '0;
                    lo_next       = lo_probe;
                    hp_next       = hp_probe;
                    mid_next      = mid_probe;
                    rd_addr       = mid_probe;
                end
            end
            DP_SORT_INIT:
            begin
                i_next  = IDX_W'(1);
                j_next  = IDX_W'(1);
                rd_addr = IDX_W'(1);
            end
            DP_SORT_KEY:
            begin
                key_next = rd_reg;
                rd_addr  = j_reg - IDX_W'(1);
            end
            DP_SORT_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = rd_reg;
                j_next  = j_reg - IDX_W'(1);
                rd_addr = j_reg - IDX_W'(2);
            end
            DP_SORT_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = key_reg;
                i_next  = i_reg + IDX_W'(1);
                j_next  = i_reg + IDX_W'(1);
                rd_addr = i_reg + IDX_W'(1);
                if (dp_sts.sort_last)
                begin
                    ready_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hp_reg       <= hp_next;
        mid_reg      <= mid_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        status_reg   <= status_next;
        position_reg <= position_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            ready_reg <= ready_next;
        end
    end

endmodule

### rtl/sorted_table_binary_search.sv
// Top level of the sorted table with binary search: controller plus datapath.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low. With mode low the request loads item_value as the next table entry;
// with mode high it searches the table for item_value. Loads give no result.
// When the sixteenth value of a table arrives, the block sorts the table in
// place with an insertion sort over its table memory, which takes one write
// and one registered read per cycle, and holds busy high meanwhile: it sets
// up, then for each entry i fetches the key, shifts every larger entry before
// it up by one place and writes the key into the gap.
// A further load after a full table starts a new table at entry zero.
// A search answers with done high for exactly one cycle, together with status
// (found, not found, table not ready) and position. A search on a table that
// is not ready answers in the next cycle and leaves busy low. Otherwise busy
// is high while the search probes the table, one table read per probe, and
// done follows in the cycle after the last probe. The memory read data is
// registered. The receiver cannot stall, so each result is presented once
// and must be taken then.
// Reset clears the fill count and the ready flag; the table contents are
// undefined until loaded.
module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     mode,
    input  logic signed [DATA_W-1:0] item_value,
    output logic                     done,
    output logic [STAT_W-1:0]        status,
    output logic [POS_W-1:0]         position
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // The controller decides what the datapath does in each cycle.
    stbs_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .dp_sts (dp_sts),
        .dp_cmd (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath holds the table, the search bounds and the result registers.
    stbs_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .item_value (item_value),
        .dp_sts     (dp_sts),
        .status     (status),
        .position   (position)
    );

endmodule

### tb/sv/testbench.sv
// Testbench for the sorted table binary search: a queue-fed request driver and a result monitor.
`timescale 1ns / 1ps

module testbench;
    import stbs_pkg::*;

    // The two kinds of request that the mode port selects.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // Number of random requests after the directed part.
    localparam int RANDOM_REQUESTS = 1800;
    // Long enough to cover a full sort, the block's own work at the end.
    localparam int SETTLE_CYCLES = 200;
    // Cycle limit, with a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic                     mode;
        logic signed [DATA_W-1:0] value;
        bit                       hold_until_drained;
    } table_request_t;

    typedef struct {
        status_t           status;
        logic [POS_W-1:0]  position;
    } lookup_result_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic mode = MODE_LOAD;
    logic signed [DATA_W-1:0] item_value = '0;
    logic busy;
    logic done;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0] position;

    sorted_table_binary_search uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .item_value (item_value),
        .done       (done),
        .status     (status),
        .position   (position)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Requests waiting to be driven, and the answers that accepted searches must produce.
    table_request_t request_queue[$];
    lookup_result_t lookup_answers[$];

    // The testbench's own copy of the table, updated as requests are accepted.
    logic signed [DATA_W-1:0] shadow_table [ENTRIES];
    int unsigned shadow_fill = 0;
    bit          shadow_ready = 1'b0;

    // A second copy, updated as requests are generated, so that search keys can be drawn
    // from the values that will be in the table when the search arrives.
    logic signed [DATA_W-1:0] planned_values [ENTRIES];
    int unsigned planned_fill = 0;

    int total_requests = 0;
    int accepted_count = 0;
    int error_count = 0;
    int cycle_count = 0;
    int load_count = 0;
    int search_count = 0;
    int tables_built = 0;
    int found_count = 0;
    int missing_count = 0;
    int not_ready_count = 0;

    // Sender idling: a burst of back-to-back requests, then a gap of idle cycles.
    int burst_left = 8;
    int gap_left = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Ascending exchange sort; equal entries are identical, so the order among them
    // cannot change any answer.
    function automatic void sort_shadow_table();
        logic signed [DATA_W-1:0] swap;
        for (int i = 0; i < ENTRIES - 1; i++)
        begin
            for (int j = i + 1; j < ENTRIES; j++)
            begin
                if (shadow_table[j] < shadow_table[i])
                begin
                    swap = shadow_table[i];
                    shadow_table[i] = shadow_table[j];
                    shadow_table[j] = swap;
                end
            end
        end
    endfunction

    // A load into a full table starts a fresh one at entry zero. The sixteenth value
    // of a table triggers the sort and marks the table ready.
    function automatic void store_value(input logic signed [DATA_W-1:0] value);
        if (shadow_fill >= ENTRIES)
        begin
            shadow_fill = 0;
            shadow_ready = 1'b0;
        end
        shadow_table[shadow_fill] = value;
        shadow_fill++;
        if (shadow_fill == ENTRIES)
        begin
            sort_shadow_table();
            shadow_ready = 1'b1;
            tables_built++;
        end
    endfunction

    // Plain binary search over the sorted copy. With duplicates, the first probe that
    // hits the key decides the reported position.
    function automatic lookup_result_t lookup_key(input logic signed [DATA_W-1:0] key);
        lookup_result_t answer;
        int lo;
        int hi;
        int mid;
        answer.status = STATUS_NOT_FOUND;
        answer.position = '0;
        if (!shadow_ready)
        begin
            answer.status = STATUS_NOT_READY;
            return answer;
        end
        lo = 0;
        hi = ENTRIES - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (shadow_table[mid] == key)
            begin
                answer.status = STATUS_FOUND;
                answer.position = POS_W'(mid);
                return answer;
            end
            if (key > shadow_table[mid])
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return answer;
    endfunction

    task automatic queue_request(input logic req_mode, input logic signed [DATA_W-1:0] value,
                                 input bit hold);
        table_request_t req;
        req.mode = req_mode;
        req.value = value;
        req.hold_until_drained = hold;
        request_queue.push_back(req);
        total_requests++;
        if (req_mode == MODE_LOAD)
        begin
            if (planned_fill >= ENTRIES)
                planned_fill = 0;
            planned_values[planned_fill] = value;
            planned_fill++;
        end
    endtask

    function automatic logic signed [DATA_W-1:0] extreme_value();
        case ($urandom_range(0, 3))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            default: return 32'shffff_ffff;
        endcase
    endfunction

    // Table contents come in three flavors: fully random words, a narrow band around zero
    // that forces many duplicates, and a mix of both. Extremes are sprinkled into all of them.
    function automatic logic signed [DATA_W-1:0] table_value(input int flavor);
        if ($urandom_range(0, 7) == 0)
            return extreme_value();
        if (flavor == 1 || (flavor == 2 && $urandom_range(0, 1) == 0))
            return $signed(DATA_W'($urandom_range(0, 20))) - 10;
        return $signed($urandom());
    endfunction

    // Most keys are present in the table; the rest sit just beside an entry, are random,
    // or are extremes, so that misses happen at every point of the probe sequence.
    function automatic logic signed [DATA_W-1:0] search_key();
        logic signed [DATA_W-1:0] picked;
        int roll;
        picked = planned_values[$urandom_range(0, ENTRIES - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return picked;
        if (roll < 63)
            return picked + 1;
        if (roll < 70)
            return picked - 1;
        if (roll < 90)
            return $signed($urandom());
        return extreme_value();
    endfunction

    function automatic int pick_gap();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return $urandom_range(2, 5);
            default: return $urandom_range(6, 20);
        endcase
    endfunction

    // Request driver. A request stays on the ports until it is accepted at an edge where
    // start is high and busy is low. Only then, or while start is low, is the next
    // decision taken, so every signal gets one nonblocking assignment per edge.
    always @(posedge clk)
    begin
        logic fire;
        table_request_t next_req;
        fire = start && !busy;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                accepted_count++;
                if (mode == MODE_LOAD)
                begin
                    load_count++;
                    store_value(item_value);
                end
                else
                begin
                    search_count++;
                    lookup_answers.push_back(lookup_key(item_value));
                end
            end
            if (!start || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (request_queue.size() == 0)
                begin
                    start <= 1'b0;
                end
                else if (request_queue[0].hold_until_drained && lookup_answers.size() != 0)
                begin
                    // Pause until every outstanding search has answered.
                    start <= 1'b0;
                end
                else
                begin
                    next_req = request_queue.pop_front();
                    start <= 1'b1;
                    mode <= next_req.mode;
                    item_value <= next_req.value;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = pick_gap();
                    end
                end
            end
        end
    end

    // Result monitor. The receiver cannot hold results off, so each done pulse is
    // checked at the edge that ends it against the oldest outstanding answer.
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && done)
        begin
            if (lookup_answers.size() == 0)
            begin
                report_mismatch($sformatf("result with no search outstanding: %0d %0d",
                                          status, position));
            end
            else
            begin
                want = lookup_answers.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (position !== want.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              position, want.position));
                case (want.status)
                    STATUS_FOUND: found_count++;
                    STATUS_NOT_FOUND: missing_count++;
                    default: not_ready_count++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d searches still unanswered.",
                     cycle_count, lookup_answers.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int flavor;
        int searches;
        bit interleave;

        // Directed part. A search on an empty table must report not ready.
        queue_request(MODE_SEARCH, 32'sd5, 1'b0);
        // A table holding both extremes, zero, minus one, alternating bit patterns and a
        // value loaded three times, given in no particular order.
        queue_request(MODE_LOAD, 32'sh7fff_ffff, 1'b0);
        queue_request(MODE_LOAD, 32'sd1000, 1'b0);
        queue_request(MODE_LOAD, 32'sd7, 1'b0);
        queue_request(MODE_LOAD, 32'sd7, 1'b0);
        queue_request(MODE_LOAD, 32'sd0, 1'b0);
        queue_request(MODE_LOAD, -32'sd1, 1'b0);
        queue_request(MODE_LOAD, -32'sd7, 1'b0);
        queue_request(MODE_LOAD, 32'sh8000_0000, 1'b0);
        queue_request(MODE_LOAD, 32'sh5555_5555, 1'b0);
        queue_request(MODE_LOAD, 32'shaaaa_aaaa, 1'b0);
        queue_request(MODE_LOAD, 32'sd12345, 1'b0);
        queue_request(MODE_LOAD, -32'sd12345, 1'b0);
        queue_request(MODE_LOAD, 32'sd7, 1'b0);
        queue_request(MODE_LOAD, 32'sd1, 1'b0);
        queue_request(MODE_LOAD, 32'sd2, 1'b0);
        queue_request(MODE_LOAD, -32'sd2, 1'b0);
        // Smallest and largest entries, the duplicated value, and a key that is absent.
        queue_request(MODE_SEARCH, 32'sh8000_0000, 1'b0);
        queue_request(MODE_SEARCH, 32'sh7fff_ffff, 1'b0);
        queue_request(MODE_SEARCH, 32'sd7, 1'b0);
        queue_request(MODE_SEARCH, 32'sd3, 1'b0);
        // A load into the full table starts a new one, so the next search is not ready.
        queue_request(MODE_LOAD, 32'sd99, 1'b0);
        queue_request(MODE_SEARCH, 32'sd99, 1'b0);

        // Random part. Most sequences finish a table and then search it. Some drop
        // searches in while the table is filling, and a few add stray loads that shift
        // where the next table begins. In two stretches the sender drains before a table.
        while (total_requests < RANDOM_REQUESTS + 23)
        begin
            flavor = $urandom_range(0, 2);
            interleave = ($urandom_range(0, 9) == 0);
            for (int e = 0; e < ENTRIES; e++)
            begin
                queue_request(MODE_LOAD, table_value(flavor),
                              (e == 0) && (total_requests >= 23 && total_requests < 40 ||
                                           total_requests >= 900 && total_requests < 960));
                if (interleave && $urandom_range(0, 3) == 0)
                    queue_request(MODE_SEARCH, search_key(), 1'b0);
            end
            searches = $urandom_range(3, 15);
            for (int s = 0; s < searches; s++)
                queue_request(MODE_SEARCH, search_key(), 1'b0);
            if ($urandom_range(0, 19) == 0)
            begin
                for (int e = $urandom_range(1, 5); e > 0; e--)
                    queue_request(MODE_LOAD, table_value(flavor), 1'b0);
                queue_request(MODE_SEARCH, search_key(), 1'b0);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request has been accepted and every search has answered,
        // then let a possible sort run out before closing.
        while (accepted_count < total_requests)
            @(posedge clk);
        while (lookup_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d loads filling %0d complete tables, and %0d searches:",
                 load_count, tables_built, search_count);
        $display("%0d found, %0d not found, %0d issued before the table was ready.",
                 found_count, missing_count, not_ready_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
